/* rtl/fvg_pkg.sv */
`default_nettype none
package fvg_pkg;

   // root directory entry is 32 bytes: multiply by shifting
   localparam int ENTRY_SHIFT = 5;
   localparam int DIVIDEND_W  = 16 + ENTRY_SHIFT + 1;   // entries*32 + (bps-1)

   localparam logic [31:0] LIMIT_FAT12 = 32'd4085;
   localparam logic [31:0] LIMIT_FAT16 = 32'd65525;
   localparam logic [31:0] LIMIT_FAT32 = 32'd268435445;

   localparam logic [1:0] KIND_FAT12 = 2'd0;
   localparam logic [1:0] KIND_FAT16 = 2'd1;
   localparam logic [1:0] KIND_FAT32 = 2'd2;
   localparam logic [1:0] KIND_EXFAT = 2'd3;

   // carried alongside the root directory divide
   typedef struct packed {
      logic [31:0] vol;
      logic [31:0] tbl;
      logic [15:0] rsv;
      logic [31:0] root_first;
      logic [7:0]  spc;
      logic        bps_zero;
   } front_pay_type;

   // one queue entry between front and back
   typedef struct packed {
      logic [31:0] vol;
      logic [31:0] tbl;
      logic [15:0] rds;
      logic [15:0] rsv;
      logic [31:0] root_first;
      logic [31:0] data_first;
      logic [7:0]  spc;
      logic        fault;
   } geom_item_type;

   // carried alongside the cluster divide
   typedef struct packed {
      logic [31:0] vol;
      logic [31:0] tbl;
      logic [15:0] rds;
      logic [15:0] rsv;
      logic [31:0] root_first;
      logic [31:0] data_first;
      logic [31:0] data;
      logic        spc_zero;
      logic        fault;
   } back_pay_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage
`default_nettype wire

/* rtl/fvg_div_pipe.sv */
`default_nettype none
// Restoring divider, one quotient bit per stage, NUM_W stages after the input register.
module fvg_div_pipe #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 8,
   parameter int PAY_W = 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire logic [NUM_W-1:0] in_num,
   input  wire logic [DEN_W-1:0] in_den,
   input  wire logic [PAY_W-1:0] in_pay,
   output logic                  out_valid,
   output logic      [NUM_W-1:0] out_quot,
   output logic      [PAY_W-1:0] out_pay
);

   logic             valid_ff [NUM_W+1];
   logic             valid_in [NUM_W+1];
   logic [DEN_W-1:0] rem_ff   [NUM_W+1];
   logic [DEN_W-1:0] rem_in   [NUM_W+1];
   logic [NUM_W-1:0] num_ff   [NUM_W+1];
   logic [NUM_W-1:0] num_in   [NUM_W+1];
   logic [DEN_W-1:0] den_ff   [NUM_W+1];
   logic [DEN_W-1:0] den_in   [NUM_W+1];
   logic [PAY_W-1:0] pay_ff   [NUM_W+1];
   logic [PAY_W-1:0] pay_in   [NUM_W+1];

   always_comb begin
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      logic           ge;
      valid_in[0] = in_valid;
      rem_in[0]   = '0;
      num_in[0]   = in_num;
      den_in[0]   = in_den;
      pay_in[0]   = in_pay;
      for (int k = 1; k <= NUM_W; k++) begin
         trial       = {rem_ff[k-1], num_ff[k-1][NUM_W-1]};
         diff        = trial - {1'b0, den_ff[k-1]};
         ge          = (trial >= {1'b0, den_ff[k-1]});
         rem_in[k]   = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         num_in[k]   = {num_ff[k-1][NUM_W-2:0], ge};
         valid_in[k] = valid_ff[k-1];
         den_in[k]   = den_ff[k-1];
         pay_in[k]   = pay_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NUM_W; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         valid_ff <= valid_in;
      end
      if (en) begin
         rem_ff <= rem_in;
         num_ff <= num_in;
         den_ff <= den_in;
         pay_ff <= pay_in;
      end
   end

   assign out_valid = valid_ff[NUM_W];
   assign out_quot  = num_ff[NUM_W];
   assign out_pay   = pay_ff[NUM_W];

endmodule
`default_nettype wire

/* rtl/fvg_front.sv */
`default_nettype none
module fvg_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [15:0]            req_bytes_per_sector,
   input  wire logic [7:0]             req_sectors_per_cluster,
   input  wire logic [15:0]            req_reserved_sectors,
   input  wire logic [7:0]             req_fat_copies,
   input  wire logic [15:0]            req_root_entries,
   input  wire logic [15:0]            req_total_sectors_short,
   input  wire logic [31:0]            req_total_sectors_long,
   input  wire logic [15:0]            req_fat_size_short,
   input  wire logic [31:0]            req_fat_size_long,
   input  wire fvg_pkg::queue_stat_type q_stat,
   input  wire logic                   q_pop,
   output logic                        push,
   output fvg_pkg::geom_item_type      push_item
);
   import fvg_pkg::*;

   localparam int PAY_W = $bits(front_pay_type);

   logic                  en;
   logic                  accept;
   logic [31:0]           vol_sel;
   logic [31:0]           tbl_sel;
   logic [39:0]           prod;
   logic [DIVIDEND_W-1:0] dividend;
   front_pay_type         pay_in;
   front_pay_type         pay_out;
   logic [PAY_W-1:0]      pay_out_bits;
   logic [DIVIDEND_W-1:0] quot;
   logic [DIVIDEND_W-1:0] rds;
   logic                  div_valid;

   // hold the whole pipe only if the queue is full and not draining
   assign en     = !(div_valid && q_stat.full && !q_pop);
   assign busy   = !en;
   assign accept = start && en;

   always_comb begin
      vol_sel = (req_total_sectors_short == 16'd0) ? req_total_sectors_long
                                                   : {16'd0, req_total_sectors_short};
      tbl_sel = (req_fat_size_short == 16'd0) ? req_fat_size_long
                                              : {16'd0, req_fat_size_short};
      prod    = {32'd0, req_fat_copies} * {8'd0, tbl_sel};
      // entries*32 + bps - 1; garbage when bps is zero, result dropped then
      dividend = {1'b0, req_root_entries, {ENTRY_SHIFT{1'b0}}}
               + {{(DIVIDEND_W-16){1'b0}}, req_bytes_per_sector}
               - {{(DIVIDEND_W-1){1'b0}}, 1'b1};
      pay_in.vol        = vol_sel;
      pay_in.tbl        = tbl_sel;
      pay_in.rsv        = req_reserved_sectors;
      pay_in.root_first = {16'd0, req_reserved_sectors} + prod[31:0];
      pay_in.spc        = req_sectors_per_cluster;
      pay_in.bps_zero   = (req_bytes_per_sector == 16'd0);
   end

   fvg_div_pipe #(
      .NUM_W(DIVIDEND_W),
      .DEN_W(16),
      .PAY_W(PAY_W)
   ) u_root_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (accept),
      .in_num   (dividend),
      .in_den   (req_bytes_per_sector),
      .in_pay   (pay_in),
      .out_valid(div_valid),
      .out_quot (quot),
      .out_pay  (pay_out_bits)
   );

   always_comb begin
      pay_out              = front_pay_type'(pay_out_bits);
      rds                  = pay_out.bps_zero ? '0 : quot;
      push_item.vol        = pay_out.vol;
      push_item.tbl        = pay_out.tbl;
      push_item.rds        = rds[15:0];
      push_item.rsv        = pay_out.rsv;
      push_item.root_first = pay_out.root_first;
      push_item.data_first = pay_out.root_first + {{(32-DIVIDEND_W){1'b0}}, rds};
      push_item.spc        = pay_out.spc;
      push_item.fault      = pay_out.bps_zero;
   end

   assign push = div_valid && en;

endmodule
`default_nettype wire

/* rtl/fvg_queue.sv */
`default_nettype none
module fvg_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire fvg_pkg::geom_item_type push_item,
   input  wire logic                   pop,
   output fvg_pkg::queue_stat_type     q_stat,
   output fvg_pkg::geom_item_type      head
);
   import fvg_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   geom_item_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign q_stat.full  = (count_ff == CNT_W'(DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign head         = entry_ff[rd_ptr_ff];

endmodule
`default_nettype wire

/* rtl/fvg_back.sv */
`default_nettype none
module fvg_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire fvg_pkg::queue_stat_type q_stat,
   input  wire fvg_pkg::geom_item_type head,
   output logic                        pop,
   output logic                        rsp_valid,
   output logic [31:0]                 rsp_volume_sectors,
   output logic [31:0]                 rsp_table_sectors,
   output logic [15:0]                 rsp_root_size,
   output logic [15:0]                 rsp_first_table_sector,
   output logic [31:0]                 rsp_first_root_sector,
   output logic [31:0]                 rsp_first_data_area_sector,
   output logic [31:0]                 rsp_data_area_sectors,
   output logic [31:0]                 rsp_cluster_count,
   output logic [1:0]                  rsp_fat_kind,
   output logic                        rsp_divide_fault
);
   import fvg_pkg::*;

   localparam int PAY_W = $bits(back_pay_type);

   back_pay_type     pay_in;
   back_pay_type     pay_out;
   logic [PAY_W-1:0] pay_out_bits;
   logic [31:0]      quot;
   logic             div_valid;
   logic [31:0]      clusters;
   logic [1:0]       kind;

   logic             valid_ff;
   logic [31:0]      vol_ff, tbl_ff, root_first_ff, data_first_ff, data_ff, clusters_ff;
   logic [15:0]      rds_ff, rsv_ff;
   logic [1:0]       kind_ff;
   logic             fault_ff;

   // results cannot be held off, so the back end drains every cycle
   assign pop = !q_stat.empty;

   always_comb begin
      pay_in.vol        = head.vol;
      pay_in.tbl        = head.tbl;
      pay_in.rds        = head.rds;
      pay_in.rsv        = head.rsv;
      pay_in.root_first = head.root_first;
      pay_in.data_first = head.data_first;
      pay_in.data       = head.vol - head.data_first;
      pay_in.spc_zero   = (head.spc == 8'd0);
      pay_in.fault      = head.fault;
   end

   fvg_div_pipe #(
      .NUM_W(32),
      .DEN_W(8),
      .PAY_W(PAY_W)
   ) u_cluster_div (
      .clock    (clock),
      .reset    (reset),
      .en       (1'b1),
      .in_valid (pop),
      .in_num   (pay_in.data),
      .in_den   (head.spc),
      .in_pay   (pay_in),
      .out_valid(div_valid),
      .out_quot (quot),
      .out_pay  (pay_out_bits)
   );

   always_comb begin
      pay_out  = back_pay_type'(pay_out_bits);
      clusters = pay_out.spc_zero ? 32'd0 : quot;
      if (clusters < LIMIT_FAT12) begin
         kind = KIND_FAT12;
      end else if (clusters < LIMIT_FAT16) begin
         kind = KIND_FAT16;
      end else if (clusters < LIMIT_FAT32) begin
         kind = KIND_FAT32;
      end else begin
         kind = KIND_EXFAT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= div_valid;
      end
      vol_ff        <= pay_out.vol;
      tbl_ff        <= pay_out.tbl;
      rds_ff        <= pay_out.rds;
      rsv_ff        <= pay_out.rsv;
      root_first_ff <= pay_out.root_first;
      data_first_ff <= pay_out.data_first;
      data_ff       <= pay_out.data;
      clusters_ff   <= clusters;
      kind_ff       <= kind;
      fault_ff      <= pay_out.fault || pay_out.spc_zero;
   end

   assign rsp_valid                  = valid_ff;
   assign rsp_volume_sectors         = vol_ff;
   assign rsp_table_sectors          = tbl_ff;
   assign rsp_root_size              = rds_ff;
   assign rsp_first_table_sector     = rsv_ff;
   assign rsp_first_root_sector      = root_first_ff;
   assign rsp_first_data_area_sector = data_first_ff;
   assign rsp_data_area_sectors      = data_ff;
   assign rsp_cluster_count          = clusters_ff;
   assign rsp_fat_kind               = kind_ff;
   assign rsp_divide_fault           = fault_ff;

endmodule
`default_nettype wire

/* rtl/fat_volume_geometry_unit.sv */
`default_nettype none
// FAT volume geometry. Drive one boot sector parameter block on the req_ ports
// with start high; it is taken on a clock edge where busy is low. One beat per
// cycle is accepted while busy is low. Each block gives exactly one result
// beat, in order, on the rsp_ ports for a single cycle marked by rsp_valid;
// the receiver cannot stall and must take it then. Each block passes through
// two pipelined restoring dividers: the root directory size (22 quotient bits,
// one per stage) in the front end and the cluster count (32 quotient bits) in
// the back end, with a small queue between them. busy rises only if that queue
// is full and not draining, which the always-ready back end never lets happen,
// so in practice busy stays low. A zero sector size or cluster size forces the
// matching quotient to zero and raises rsp_divide_fault; sums and differences
// wrap modulo 2^32.
module fat_volume_geometry_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [15:0] req_bytes_per_sector,
   input  wire logic [7:0]  req_sectors_per_cluster,
   input  wire logic [15:0] req_reserved_sectors,
   input  wire logic [7:0]  req_fat_copies,
   input  wire logic [15:0] req_root_entries,
   input  wire logic [15:0] req_total_sectors_short,
   input  wire logic [31:0] req_total_sectors_long,
   input  wire logic [15:0] req_fat_size_short,
   input  wire logic [31:0] req_fat_size_long,
   output logic             rsp_valid,
   output logic [31:0]      rsp_volume_sectors,
   output logic [31:0]      rsp_table_sectors,
   output logic [15:0]      rsp_root_size,
   output logic [15:0]      rsp_first_table_sector,
   output logic [31:0]      rsp_first_root_sector,
   output logic [31:0]      rsp_first_data_area_sector,
   output logic [31:0]      rsp_data_area_sectors,
   output logic [31:0]      rsp_cluster_count,
   output logic [1:0]       rsp_fat_kind,
   output logic             rsp_divide_fault
);
   import fvg_pkg::*;

   queue_stat_type q_stat;
   geom_item_type  push_item;
   geom_item_type  head;
   logic           push;
   logic           pop;

   // front: field selection, table offsets, root directory divide
   fvg_front u_front (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_bytes_per_sector   (req_bytes_per_sector),
      .req_sectors_per_cluster(req_sectors_per_cluster),
      .req_reserved_sectors   (req_reserved_sectors),
      .req_fat_copies         (req_fat_copies),
      .req_root_entries       (req_root_entries),
      .req_total_sectors_short(req_total_sectors_short),
      .req_total_sectors_long (req_total_sectors_long),
      .req_fat_size_short     (req_fat_size_short),
      .req_fat_size_long      (req_fat_size_long),
      .q_stat                 (q_stat),
      .q_pop                  (pop),
      .push                   (push),
      .push_item              (push_item)
   );

   // decouples the two halves
   fvg_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_item(push_item),
      .pop      (pop),
      .q_stat   (q_stat),
      .head     (head)
   );

   // back: data area, cluster divide, type classification, result register
   fvg_back u_back (
      .clock                     (clock),
      .reset                     (reset),
      .q_stat                    (q_stat),
      .head                      (head),
      .pop                       (pop),
      .rsp_valid                 (rsp_valid),
      .rsp_volume_sectors        (rsp_volume_sectors),
      .rsp_table_sectors         (rsp_table_sectors),
      .rsp_root_size             (rsp_root_size),
      .rsp_first_table_sector    (rsp_first_table_sector),
      .rsp_first_root_sector     (rsp_first_root_sector),
      .rsp_first_data_area_sector(rsp_first_data_area_sector),
      .rsp_data_area_sectors     (rsp_data_area_sectors),
      .rsp_cluster_count         (rsp_cluster_count),
      .rsp_fat_kind              (rsp_fat_kind),
      .rsp_divide_fault          (rsp_divide_fault)
   );

endmodule
`default_nettype wire
